FILE: src/cpa_pkg.sv
// shared types and constants of the contiguous page allocator
package cpa_pkg;

	localparam int NUM_PAGES_DEF  = 64;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int REQ_BYTES_W = 20;
	localparam int ADDR_W      = 16;
	localparam int PAGES_OUT_W = 11;
	localparam int BYTES_OUT_W = 21;

	// allocation address is (start page + ADDR_OFFSET) << ADDR_SHIFT
	localparam int ADDR_OFFSET = 14;
	localparam int ADDR_SHIFT  = 3;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_NO_RUN    = 3'd2,
		ST_FREED     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		op_t                     op;
		logic [REQ_BYTES_W-1:0]  request_bytes;
		logic [ADDR_W-1:0]       free_address;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [ADDR_W-1:0]       address;
		logic [PAGES_OUT_W-1:0]  pages_free;
		logic [BYTES_OUT_W-1:0]  bytes_free;
	} rsp_t;

endpackage

FILE: src/cpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module cpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/contiguous_page_allocator.sv
// top level of the first-fit contiguous page allocator
//
// One request is taken at a time and gives one response. Each page has a record
// of used bit, tag, run length and byte count. All records sit in one ram with a
// registered read. After reset a clearing pass marks every record unused, and
// requests stall meanwhile. An allocate works out its page count with a
// reciprocal multiply (DIVIDE) and checks the free counts (CHECK). It then reads
// the used bits from page 0 to find the first free run (one page per cycle).
// Last it writes the run record into every page of the run (one page per
// cycle). A free computes the start page from the address and reads that
// page's record (LOOKUP, MATCH). It then clears the used bit of each page of
// the run (one per cycle). The DONE state then loads the response register;
// it waits there while a previous response is still held under stall.
module contiguous_page_allocator
	import cpa_pkg::*;
#(
	parameter int NUM_PAGES  = NUM_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CNT_W  = $clog2(NUM_PAGES + 1);
	localparam longint TOTAL_BYTES = longint'(NUM_PAGES) * longint'(PAGE_BYTES);
	localparam int BYTE_W = $clog2(TOTAL_BYTES + 1);
	localparam int CMP_W  = (BYTE_W > REQ_BYTES_W) ? BYTE_W : REQ_BYTES_W;
	localparam int NEED_W = REQ_BYTES_W + 1;
	localparam int RCP_SH = REQ_BYTES_W + $clog2(PAGE_BYTES);
	localparam int RCP_W  = REQ_BYTES_W + 1;
	localparam int PROD_W = REQ_BYTES_W + RCP_W;
	localparam longint RCP = ((longint'(1) << RCP_SH) + longint'(PAGE_BYTES) - longint'(1))
	                         / longint'(PAGE_BYTES);
	localparam int REC_W  = 1 + ADDR_W + CNT_W + REQ_BYTES_W;
	localparam int PIDX_W = ADDR_W - ADDR_SHIFT;

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		DIVIDE,
		CHECK,
		SCAN,
		FILL,
		LOOKUP,
		MATCH,
		RELEASE,
		DONE
	} state_t;

	state_t                 state_q;
	req_t                   req_q;
	logic [CNT_W-1:0]       free_pages_q;
	logic [BYTE_W-1:0]      free_bytes_q;
	logic [NEED_W-1:0]      need_q;
	logic [IDX_W-1:0]       scan_idx_q;
	logic [CNT_W-1:0]       run_q;
	logic [IDX_W-1:0]       walk_idx_q;
	logic [CNT_W-1:0]       walk_cnt_q;
	status_t                status_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	// page count from a multiply by the rounded-up reciprocal of PAGE_BYTES
	logic [PROD_W-1:0] need_prod;

	assign need_prod = PROD_W'(req_q.request_bytes) * PROD_W'(RCP);

	// record ram: used bit, tag, run pages, run bytes
	logic             ram_we;
	logic [IDX_W-1:0] ram_raddr;
	logic [REC_W-1:0] ram_wdata;
	logic [REC_W-1:0] ram_rdata;
	logic                   rec_used;
	logic [ADDR_W-1:0]      rec_tag;
	logic [CNT_W-1:0]       rec_pages;
	logic [REQ_BYTES_W-1:0] rec_bytes;

	// first-fit scan step
	logic             scan_used;
	logic [CNT_W-1:0] need_cnt;
	logic [CNT_W-1:0] run_next;
	logic             scan_found;
	logic             scan_last;
	logic [IDX_W-1:0] run_start;
	logic [ADDR_W-1:0] run_tag;

	// scan data arrives the cycle after its read, page scan_idx_q is on rdata
	assign scan_used  = rec_used;
	assign need_cnt   = CNT_W'(need_q);
	assign run_next   = scan_used ? '0 : run_q + CNT_W'(1);
	assign scan_found = !scan_used && (run_next == need_cnt);
	assign scan_last  = scan_idx_q == IDX_W'(NUM_PAGES - 1);
	assign run_start  = scan_idx_q - IDX_W'(need_cnt - CNT_W'(1));
	assign run_tag    = ADDR_W'((32'(run_start) + 32'(ADDR_OFFSET)) << ADDR_SHIFT);

	// start page implied by a free address
	logic [PIDX_W-1:0] free_page;
	logic              free_page_ok;
	logic [IDX_W-1:0]  free_idx;

	assign free_page    = req_q.free_address[ADDR_W-1:ADDR_SHIFT] - PIDX_W'(ADDR_OFFSET);
	assign free_page_ok = (req_q.free_address[ADDR_SHIFT-1:0] == '0)
	                   && (req_q.free_address[ADDR_W-1:ADDR_SHIFT] >= PIDX_W'(ADDR_OFFSET))
	                   && (free_page < PIDX_W'(NUM_PAGES));
	assign free_idx     = IDX_W'(free_page);

	assign ram_we    = (state_q == FILL) || (state_q == RELEASE) || (state_q == CLEAR);
	assign ram_raddr = (state_q == LOOKUP) ? free_idx
	                 : ((state_q == SCAN) ? scan_idx_q + IDX_W'(1) : '0);
	assign ram_wdata = (state_q == FILL) ? {1'b1, addr_q, need_cnt, req_q.request_bytes} : '0;
	assign rec_used  = ram_rdata[REC_W-1];
	assign rec_tag   = ram_rdata[REC_W-2 -: ADDR_W];
	assign rec_pages = ram_rdata[REQ_BYTES_W +: CNT_W];
	assign rec_bytes = ram_rdata[REQ_BYTES_W-1:0];

	cpa_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_PAGES)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (walk_idx_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CLEAR;
			walk_idx_q   <= '0;
			free_pages_q <= CNT_W'(NUM_PAGES);
			free_bytes_q <= BYTE_W'(TOTAL_BYTES);
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					walk_idx_q <= walk_idx_q + IDX_W'(1);
					if (walk_idx_q == IDX_W'(NUM_PAGES - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						addr_q  <= '0;
						state_q <= (req.op == OP_FREE) ? LOOKUP : DIVIDE;
					end
				end
				DIVIDE: begin
					need_q  <= NEED_W'(need_prod >> RCP_SH) + NEED_W'(1);
					state_q <= CHECK;
				end
				CHECK: begin
					scan_idx_q <= '0;
					run_q      <= '0;
					if ((CMP_W'(req_q.request_bytes) > CMP_W'(free_bytes_q))
					    || (need_q > NEED_W'(free_pages_q))) begin
						status_q <= ST_TOO_LARGE;
						state_q  <= DONE;
					end else if (need_q > NEED_W'(NUM_PAGES)) begin
						status_q <= ST_NO_RUN;
						state_q  <= DONE;
					end else begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					run_q      <= run_next;
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_found) begin
						walk_idx_q   <= run_start;
						walk_cnt_q   <= need_cnt;
						addr_q       <= run_tag;
						free_pages_q <= free_pages_q - need_cnt;
						free_bytes_q <= free_bytes_q - BYTE_W'(req_q.request_bytes);
						state_q      <= FILL;
					end else if (scan_last) begin
						status_q <= ST_NO_RUN;
						state_q  <= DONE;
					end
				end
				FILL: begin
					walk_idx_q <= walk_idx_q + IDX_W'(1);
					walk_cnt_q <= walk_cnt_q - CNT_W'(1);
					if (walk_cnt_q == CNT_W'(1)) begin
						status_q <= ST_ALLOCATED;
						state_q  <= DONE;
					end
				end
				LOOKUP: begin
					walk_idx_q <= free_idx;
					// record read issued here lands in MATCH
					if (free_page_ok) begin
						state_q <= MATCH;
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q  <= DONE;
					end
				end
				MATCH: begin
					if (rec_used && (rec_tag == req_q.free_address)) begin
						walk_cnt_q   <= rec_pages;
						free_pages_q <= free_pages_q + rec_pages;
						free_bytes_q <= free_bytes_q + BYTE_W'(rec_bytes);
						state_q      <= RELEASE;
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q  <= DONE;
					end
				end
				RELEASE: begin
					walk_idx_q <= walk_idx_q + IDX_W'(1);
					walk_cnt_q <= walk_cnt_q - CNT_W'(1);
					if ((walk_cnt_q <= CNT_W'(1)) || (walk_idx_q == IDX_W'(NUM_PAGES - 1))) begin
						status_q <= ST_FREED;
						state_q  <= DONE;
					end
				end
				DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status     <= status_q;
						rsp_q.address    <= addr_q;
						rsp_q.pages_free <= PAGES_OUT_W'(free_pages_q);
						rsp_q.bytes_free <= BYTES_OUT_W'(free_bytes_q);
						rsp_valid_q      <= 1'b1;
						state_q          <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// a stalled response holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled response changed");

	a_pages_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_pages_q <= CNT_W'(NUM_PAGES))
		else $error("free page count above table size");

	// a successful allocation always reports a nonzero address
	a_alloc_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status == ST_ALLOCATED)) |-> (rsp_q.address != '0))
		else $error("allocation reported with zero address");

	// fill and release walks never run while a request is being taken
	a_walk_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == FILL) || (state_q == RELEASE)) |-> req_stall)
		else $error("page walk while accepting requests");
`endif

endmodule

FILE: tb/tb_contiguous_page_allocator.sv
// self-checking testbench for the first-fit contiguous page allocator
module tb_contiguous_page_allocator;
	import cpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES   = NUM_PAGES_DEF;
	localparam int PAGE_BYTES  = PAGE_BYTES_DEF;
	localparam int RANDOM_REQS = 950;
	localparam int CHUNK       = 50;
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 500;
	localparam int PAUSE_AT    = 600;
	localparam int DRAIN       = 4 * NUM_PAGES + 40;
	localparam int CYCLE_LIMIT = 1_000_000;

	// mirror of the allocator state, predicts the response of each request
	class page_alloc_scoreboard;
		bit               used[NUM_PAGES];
		logic [ADDR_W-1:0] tag[NUM_PAGES];
		int               run_len[NUM_PAGES];
		int               run_bytes[NUM_PAGES];
		int               pages_left;
		int               bytes_left;
		rsp_t             expected_q[$];
		logic [ADDR_W-1:0] live_addr[$];
		int               errors;
		int               checked;

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				tag[i] = '0;
				run_len[i] = 0;
				run_bytes[i] = 0;
			end
			pages_left = NUM_PAGES;
			bytes_left = NUM_PAGES * PAGE_BYTES;
			errors = 0;
			checked = 0;
		endfunction

		function rsp_t predict(req_t r);
			rsp_t e;
			int need;
			int nbytes;
			int first;
			bit fits;
			logic [ADDR_W-1:0] a;
			e.address = '0;
			if (r.op == OP_ALLOC) begin
				nbytes = int'(r.request_bytes);
				need = nbytes / PAGE_BYTES + 1;
				if (nbytes > bytes_left || need > pages_left)
					e.status = ST_TOO_LARGE;
				else begin
					e.status = ST_NO_RUN;
					if (need <= NUM_PAGES) begin
						for (int s = 0; s + need <= NUM_PAGES; s++) begin
							fits = 1'b1;
							for (int k = 0; k < need; k++)
								if (used[s + k])
									fits = 1'b0;
							if (fits) begin
								a = ADDR_W'((s + ADDR_OFFSET) << ADDR_SHIFT);
								for (int k = 0; k < need; k++) begin
									used[s + k] = 1'b1;
									tag[s + k] = a;
									run_len[s + k] = need;
									run_bytes[s + k] = nbytes;
								end
								pages_left -= need;
								bytes_left -= nbytes;
								e.status = ST_ALLOCATED;
								e.address = a;
								live_addr.push_back(a);
								break;
							end
						end
					end
				end
			end else begin
				e.status = ST_NOT_FOUND;
				first = -1;
				for (int i = 0; i < NUM_PAGES; i++)
					if (first < 0 && used[i] && tag[i] == r.free_address)
						first = i;
				if (first >= 0) begin
					pages_left += run_len[first];
					bytes_left += run_bytes[first];
					need = run_len[first];
					for (int k = 0; k < need && first + k < NUM_PAGES; k++) begin
						used[first + k] = 1'b0;
						tag[first + k] = '0;
						run_len[first + k] = 0;
						run_bytes[first + k] = 0;
					end
					foreach (live_addr[j])
						if (live_addr[j] == r.free_address) begin
							live_addr.delete(j);
							break;
						end
					e.status = ST_FREED;
				end
			end
			e.pages_free = PAGES_OUT_W'(pages_left);
			e.bytes_free = BYTES_OUT_W'(bytes_left);
			return e;
		endfunction

		function void note_request(req_t r);
			expected_q.push_back(predict(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			checked++;
			if (expected_q.size() == 0) begin
				$error("response with no request outstanding: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.address !== e.address) begin
				$error("address: expected %h, got %h", e.address, got.address);
				errors++;
			end
			if (got.pages_free !== e.pages_free) begin
				$error("pages_free: expected %0d, got %0d", e.pages_free, got.pages_free);
				errors++;
			end
			if (got.bytes_free !== e.bytes_free) begin
				$error("bytes_free: expected %0d, got %0d", e.bytes_free, got.bytes_free);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   cycles = 0;

	page_alloc_scoreboard sb = new();

	contiguous_page_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	function automatic logic [ADDR_W-1:0] page_addr(int p);
		return ADDR_W'((p + ADDR_OFFSET) << ADDR_SHIFT);
	endfunction

	function automatic req_t alloc_req(logic [REQ_BYTES_W-1:0] nbytes);
		req_t r;
		r.op = OP_ALLOC;
		r.request_bytes = nbytes;
		r.free_address = ADDR_W'($urandom());
		return r;
	endfunction

	function automatic req_t free_req(logic [ADDR_W-1:0] a);
		req_t r;
		r.op = OP_FREE;
		r.request_bytes = REQ_BYTES_W'($urandom());
		r.free_address = a;
		return r;
	endfunction

	// mostly small sizes, now and then a big one or a raw 20-bit value
	function automatic logic [REQ_BYTES_W-1:0] random_size();
		int s;
		s = $urandom_range(0, 99);
		if (s < 55)
			return REQ_BYTES_W'($urandom_range(0, PAGE_BYTES - 1));
		else if (s < 80)
			return REQ_BYTES_W'($urandom_range(PAGE_BYTES, 4 * PAGE_BYTES - 1));
		else if (s < 93)
			return REQ_BYTES_W'($urandom_range(4 * PAGE_BYTES, 16 * PAGE_BYTES - 1));
		else if (s < 98)
			return REQ_BYTES_W'($urandom_range(16 * PAGE_BYTES, NUM_PAGES * PAGE_BYTES - 1));
		return REQ_BYTES_W'($urandom());
	endfunction

	function automatic req_t random_request(int alloc_pct);
		int k;
		k = $urandom_range(0, 99);
		if (k >= 88) begin
			// noise: stray addresses, non-start pages, oversized requests
			case ($urandom_range(0, 2))
				0: return free_req(ADDR_W'($urandom()));
				1: return free_req(page_addr($urandom_range(0, NUM_PAGES - 1)));
				default: return alloc_req(REQ_BYTES_W'($urandom()));
			endcase
		end
		if (k < alloc_pct * 88 / 100 || sb.live_addr.size() == 0)
			return alloc_req(random_size());
		return free_req(sb.live_addr[$urandom_range(0, sb.live_addr.size() - 1)]);
	endfunction

	function automatic int sender_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		else if (k < 85)
			return $urandom_range(1, 3);
		else if (k < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	task automatic send_request(req_t r);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req = r;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// receiver side: alternating open and stalled stretches, one long hold-off
	initial begin
		int run_left;
		int k;
		bit stall_mode;
		bit held;
		rsp_stall = 1'b0;
		run_left = 0;
		stall_mode = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= HOLD_AFTER) begin
				held = 1'b1;
				stall_mode = 1'b1;
				run_left = HOLD_CYCLES;
			end else if (run_left == 0) begin
				k = $urandom_range(0, 99);
				stall_mode = (k >= 60);
				if (k < 30)
					run_left = $urandom_range(1, 20);
				else if (k < 60)
					run_left = $urandom_range(20, 200);
				else if (k < 95)
					run_left = $urandom_range(1, 4);
				else
					run_left = $urandom_range(5, 40);
			end
			rsp_stall = stall_mode;
			run_left--;
		end
	end

	initial begin
		int alloc_pct;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero-byte and one/two page allocations
		send_request(alloc_req(20'd0));
		send_request(alloc_req(20'(PAGE_BYTES - 1)));
		send_request(alloc_req(20'(PAGE_BYTES)));
		// a used page that is not the start of its run does not match
		send_request(free_req(page_addr(3)));
		send_request(free_req(page_addr(0)));
		send_request(free_req(page_addr(0)));
		send_request(free_req('0));
		send_request(free_req('1));
		send_request(free_req(page_addr(2) + 16'd1));
		send_request(alloc_req('1));
		send_request(alloc_req(20'(NUM_PAGES * PAGE_BYTES)));
		send_request(free_req(page_addr(1)));
		send_request(free_req(page_addr(2)));
		// whole table in one run, then nothing left
		send_request(alloc_req(20'(NUM_PAGES * PAGE_BYTES - 1)));
		send_request(alloc_req(20'd0));
		send_request(free_req(page_addr(0)));
		// fragment so the free pages exist but no run fits, then fill the table end
		send_request(alloc_req(20'd100));
		send_request(alloc_req(20'((NUM_PAGES - 4) * PAGE_BYTES)));
		send_request(free_req(page_addr(0)));
		send_request(alloc_req(20'(2 * PAGE_BYTES)));
		send_request(alloc_req(20'(PAGE_BYTES)));
		send_request(free_req(page_addr(1)));
		send_request(free_req(page_addr(NUM_PAGES - 2)));

		alloc_pct = 50;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % CHUNK == 0)
				case ($urandom_range(0, 2))
					0: alloc_pct = 25;
					1: alloc_pct = 50;
					default: alloc_pct = 80;
				endcase
			if (i == PAUSE_AT) begin
				@(negedge clk);
				req_valid = 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_request(random_request(alloc_pct));
		end
		@(negedge clk);
		req_valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
